/* rtl/gkd_pkg.sv */
// Shared widths, constants and the stored item record of the greedy knapsack block.
`timescale 1ns / 1ps
package gkd_pkg;

  // Field widths of the item and result transactions
  localparam int WEIGHT_W = 16;
  localparam int PRICE_W  = 24;
  localparam int TAG_W    = 16;
  localparam int CAP_W    = 16;
  localparam int RANK_W   = 5;
  localparam int TOTAL_W  = 29;

  // Store size default and limits of the result stream
  localparam int MAX_ITEMS_DEF = 32;
  localparam int RESULT_CAP    = 32;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Density cross-product width
  localparam int PROD_W = PRICE_W + WEIGHT_W;

  // One stored item
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [PRICE_W-1:0]  price;
    logic [TAG_W-1:0]    tag;
  } item_rec_t;

  localparam int REC_W = $bits(item_rec_t);

endpackage

/* rtl/gkd_item_if.sv */
// Input item channel: valid/ready handshake with weight, price, tag and last marker.
`timescale 1ns / 1ps
interface gkd_item_if import gkd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] item_weight;
  logic [PRICE_W-1:0]  item_price;
  logic [TAG_W-1:0]    item_tag;
  logic                last_item;

  modport source (output valid, item_weight, item_price, item_tag, last_item, input ready);
  modport sink   (input valid, item_weight, item_price, item_tag, last_item, output ready);
endinterface

/* rtl/gkd_result_if.sv */
// Result channel: valid/ready handshake carrying one ranked item and the fill summary.
`timescale 1ns / 1ps
interface gkd_result_if import gkd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RANK_W-1:0]   sorted_rank;
  logic [TAG_W-1:0]    out_tag;
  logic [WEIGHT_W-1:0] out_weight;
  logic [PRICE_W-1:0]  out_price;
  logic                taken;
  logic [PRICE_W-1:0]  taken_price;
  logic [CAP_W-1:0]    capacity_left;
  logic [TOTAL_W-1:0]  total_value;
  logic                dropped;
  logic                last_result;

  modport source (output valid, sorted_rank, out_tag, out_weight, out_price, taken,
                  taken_price, capacity_left, total_value, dropped, last_result,
                  input ready);
  modport sink   (input valid, sorted_rank, out_tag, out_weight, out_price, taken,
                  taken_price, capacity_left, total_value, dropped, last_result,
                  output ready);
endinterface

/* rtl/gkd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gkd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; hold the last data while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/greedy_knapsack_by_density.sv */
// Top level of the greedy knapsack block: item store, insertion sort, fill and result stream.
//
// Items arrive on in_ch (valid/ready) and are written to the item store, one per
// cycle. Items beyond MAX_ITEMS are discarded and reported as dropped. The item
// with last_item set closes the set: sack_capacity (written through cfg_we /
// cfg_wdata; the user must write it only while idle, the block does not enforce this) is
// sampled, and in_ch.ready drops until the set is done. The store is then stable-sorted
// ascending by price per unit weight with an insertion sort over the single-port-read
// RAM: each key is read and captured (S_KEY_RD, S_KEY_CAP), each compare multiplies,
// then shifts or stops (S_MUL, S_CMP), and S_PLACE puts a key at rank 0. The fill walks
// from the densest item, one item per cycle, until an item does not fit or none is left.
// Results go out on out_ch, rank 0 first, one per cycle while the receiver takes them;
// at most 32 results, the final one marked last_result. A stalled receiver holds the
// output register and the result walk. After the last result is loaded, new items are
// taken again. Reset (rst_n low, synchronous) clears the counters, flags, capacity and
// the taken marks; the store contents need no clearing.
`timescale 1ns / 1ps
module greedy_knapsack_by_density import gkd_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  gkd_item_if.sink            in_ch,
  gkd_result_if.source        out_ch,
  input  logic                cfg_we,
  input  logic [CAP_W-1:0]    cfg_wdata
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int EW = 7;

  typedef enum logic [9:0] {
    S_LOAD     = 10'b00_0000_0001,
    S_KEY_RD   = 10'b00_0000_0010,
    S_KEY_CAP  = 10'b00_0000_0100,
    S_MUL      = 10'b00_0000_1000,
    S_CMP      = 10'b00_0001_0000,
    S_PLACE    = 10'b00_0010_0000,
    S_FILL_RD  = 10'b00_0100_0000,
    S_FILL_CHK = 10'b00_1000_0000,
    S_EMIT_RD  = 10'b01_0000_0000,
    S_EMIT_LD  = 10'b10_0000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                ovf_r, ovf_nxt;
  logic [CAP_W-1:0]    cap_r;
  logic [CAP_W-1:0]    rem_r, rem_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic [CW-1:0]       j_r, j_nxt;
  logic [CW-1:0]       k_r, k_nxt;
  item_rec_t           key_r, key_nxt;
  item_rec_t           prev_r, prev_nxt;
  logic [PROD_W-1:0]   prod_a_r, prod_a_nxt;
  logic [PROD_W-1:0]   prod_b_r, prod_b_nxt;
  logic [MAX_ITEMS-1:0] taken_r, taken_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic [RANK_W-1:0]   o_rank_r, o_rank_nxt;
  item_rec_t           o_rec_r, o_rec_nxt;
  logic                o_taken_r, o_taken_nxt;
  logic [CAP_W-1:0]    o_cap_r, o_cap_nxt;
  logic [TOTAL_W-1:0]  o_total_r, o_total_nxt;
  logic                o_drop_r, o_drop_nxt;
  logic                o_last_r, o_last_nxt;

  // RAM port controls
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  item_rec_t           ram_wdata;
  logic [REC_W-1:0]    ram_rdata;
  item_rec_t           rd_rec;

  // Helpers
  logic                in_acc;
  logic [CW-1:0]       km1, km2;
  logic [EW-1:0]       emit_n;
  logic [TOTAL_W:0]    total_sum;
  item_rec_t           in_rec;

  gkd_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_rec      = item_rec_t'(ram_rdata);
  assign in_ch.ready = (state_r == S_LOAD);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign km1         = k_r - CW'(1);
  assign km2         = k_r - CW'(2);
  assign emit_n      = (EW'(count_r) > EW'(RESULT_CAP)) ? EW'(RESULT_CAP) : EW'(count_r);
  assign total_sum   = {1'b0, total_r} + (TOTAL_W + 1)'(rd_rec.price);

  always_comb begin
    in_rec.weight = in_ch.item_weight;
    in_rec.price  = in_ch.item_price;
    in_rec.tag    = in_ch.item_tag;
  end

  // Sequencer: load, sort, fill, emit
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    rem_nxt       = rem_r;
    total_nxt     = total_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    key_nxt       = key_r;
    prev_nxt      = prev_r;
    prod_a_nxt    = prod_a_r;
    prod_b_nxt    = prod_b_r;
    taken_nxt     = taken_r;
    out_valid_nxt = out_valid_r;
    o_rank_nxt    = o_rank_r;
    o_rec_nxt     = o_rec_r;
    o_taken_nxt   = o_taken_r;
    o_cap_nxt     = o_cap_r;
    o_total_nxt   = o_total_r;
    o_drop_nxt    = o_drop_r;
    o_last_nxt    = o_last_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[AW-1:0];
    ram_wdata     = in_rec;
    ram_re        = 1'b0;
    ram_raddr     = j_r[AW-1:0];

    // Drop the result once the receiver takes it
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          // Store the item, or drop it when the store is full
          if (count_r < CW'(MAX_ITEMS)) begin
            ram_we    = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.last_item) begin
            rem_nxt   = cap_r;
            total_nxt = '0;
            if (count_nxt > CW'(1)) begin
              j_nxt     = CW'(1);
              state_nxt = S_KEY_RD;
            end else begin
              k_nxt     = count_nxt;
              state_nxt = S_FILL_RD;
            end
          end
        end
      end
      S_KEY_RD: begin
        ram_re    = 1'b1;
        ram_raddr = j_r[AW-1:0];
        state_nxt = S_KEY_CAP;
      end
      S_KEY_CAP: begin
        // Capture the key and fetch its left neighbor
        key_nxt   = rd_rec;
        k_nxt     = j_r;
        ram_re    = 1'b1;
        ram_raddr = j_r[AW-1:0] - AW'(1);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        // Cross-products: neighbor denser than key when p_prev*w_key > p_key*w_prev
        prev_nxt   = rd_rec;
        prod_a_nxt = PROD_W'(rd_rec.price) * PROD_W'(key_r.weight);
        prod_b_nxt = PROD_W'(key_r.price) * PROD_W'(rd_rec.weight);
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = k_r[AW-1:0];
        if (prod_a_r > prod_b_r) begin
          // Shift the neighbor right and keep walking left
          ram_wdata = prev_r;
          k_nxt     = km1;
          if (km1 != '0) begin
            ram_re    = 1'b1;
            ram_raddr = km2[AW-1:0];
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_PLACE;
          end
        end else begin
          ram_wdata = key_r;
          if (j_r + CW'(1) < count_r) begin
            j_nxt     = j_r + CW'(1);
            state_nxt = S_KEY_RD;
          end else begin
            k_nxt     = count_r;
            state_nxt = S_FILL_RD;
          end
        end
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = k_r[AW-1:0];
        ram_wdata = key_r;
        if (j_r + CW'(1) < count_r) begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_KEY_RD;
        end else begin
          k_nxt     = count_r;
          state_nxt = S_FILL_RD;
        end
      end
      S_FILL_RD: begin
        ram_re    = 1'b1;
        ram_raddr = km1[AW-1:0];
        state_nxt = S_FILL_CHK;
      end
      S_FILL_CHK: begin
        if (rd_rec.weight > rem_r) begin
          k_nxt     = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          // Take the item and prefetch the next denser-first candidate
          rem_nxt                 = rem_r - rd_rec.weight;
          taken_nxt[km1[AW-1:0]] = 1'b1;
          total_nxt = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
          if (km1 != '0) begin
            k_nxt     = km1;
            ram_re    = 1'b1;
            ram_raddr = km2[AW-1:0];
          end else begin
            k_nxt     = '0;
            state_nxt = S_EMIT_RD;
          end
        end
      end
      S_EMIT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = k_r[AW-1:0];
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        // Load the output register when it is free or being taken
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_rank_nxt    = RANK_W'(k_r);
          o_rec_nxt     = rd_rec;
          o_taken_nxt   = taken_r[k_r[AW-1:0]];
          o_cap_nxt     = rem_r;
          o_total_nxt   = total_r;
          o_drop_nxt    = ovf_r;
          o_last_nxt    = (EW'(k_r) + EW'(1) == emit_n);
          if (EW'(k_r) + EW'(1) == emit_n) begin
            // Close the set
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            taken_nxt = '0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + CW'(1);
            ram_re    = 1'b1;
            ram_raddr = k_nxt[AW-1:0];
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      cap_r       <= '0;
      rem_r       <= '0;
      taken_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      rem_r       <= rem_nxt;
      taken_r     <= taken_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    total_r   <= total_nxt;
    j_r       <= j_nxt;
    k_r       <= k_nxt;
    key_r     <= key_nxt;
    prev_r    <= prev_nxt;
    prod_a_r  <= prod_a_nxt;
    prod_b_r  <= prod_b_nxt;
    o_rank_r  <= o_rank_nxt;
    o_rec_r   <= o_rec_nxt;
    o_taken_r <= o_taken_nxt;
    o_cap_r   <= o_cap_nxt;
    o_total_r <= o_total_nxt;
    o_drop_r  <= o_drop_nxt;
    o_last_r  <= o_last_nxt;
  end

  // Drive the result channel
  assign out_ch.valid         = out_valid_r;
  assign out_ch.sorted_rank   = o_rank_r;
  assign out_ch.out_tag       = o_rec_r.tag;
  assign out_ch.out_weight    = o_rec_r.weight;
  assign out_ch.out_price     = o_rec_r.price;
  assign out_ch.taken         = o_taken_r;
  assign out_ch.taken_price   = o_taken_r ? o_rec_r.price : '0;
  assign out_ch.capacity_left = o_cap_r;
  assign out_ch.total_value   = o_total_r;
  assign out_ch.dropped       = o_drop_r;
  assign out_ch.last_result   = o_last_r;

endmodule

/* sim/greedy_knapsack_by_density_tb.sv */
// Self-checking testbench for the greedy knapsack block: random sets, density-ranked predictor.
`timescale 1ns / 1ps
module greedy_knapsack_by_density_tb;
  import gkd_pkg::*;

  localparam int STORE_DEPTH  = MAX_ITEMS_DEF;
  localparam int RANDOM_ITEMS = 280;
  localparam int SETTLE_CYCLES = 8;
  localparam int LIMIT_NS     = 5_000_000;

  // One queued load transaction
  typedef struct {
    item_rec_t rec;
    logic      last;
  } load_req_t;

  // One expected ranked result
  typedef struct {
    logic [RANK_W-1:0]   rank;
    logic [TAG_W-1:0]    tag;
    logic [WEIGHT_W-1:0] weight;
    logic [PRICE_W-1:0]  price;
    logic                taken;
    logic [PRICE_W-1:0]  kept_price;
    logic [CAP_W-1:0]    room_left;
    logic [TOTAL_W-1:0]  total;
    logic                dropped;
    logic                last_one;
  } rank_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  gkd_item_if   item_ch ();
  gkd_result_if result_ch ();

  greedy_knapsack_by_density #(
    .MAX_ITEMS(MAX_ITEMS_DEF)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (item_ch),
    .out_ch   (result_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Predictor state: the set being loaded and the sack size in force
  item_rec_t        set_store [STORE_DEPTH];
  int               set_count;
  logic             set_overflow;
  logic [CAP_W-1:0] sack_size;

  load_req_t    pending_loads [$];
  rank_result_t ranks_due [$];
  int           mismatches;
  int           items_queued;
  int           load_gap;
  int           hold_left;
  bit           send_steady;
  bit           take_steady;
  load_req_t    next_load;
  rank_result_t want;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Report one failure and count it
  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input int rank, input logic [31:0] got,
                               input logic [31:0] exp_val);
    if (got !== exp_val)
      report_error($sformatf("rank %0d %s: got 0x%0h, want 0x%0h", rank, name, got, exp_val));
  endtask

  // Strict density order through exact cross-products
  function automatic bit denser(input item_rec_t a, input item_rec_t b);
    logic [63:0] lhs;
    logic [63:0] rhs;
    lhs = 64'(a.price) * 64'(b.weight);
    rhs = 64'(b.price) * 64'(a.weight);
    return lhs > rhs;
  endfunction

  // Store one item; on the closing item sort, fill the sack and queue the ranking
  task automatic predict_ranking(input item_rec_t rec, input logic closes_set);
    item_rec_t              key;
    rank_result_t           res;
    logic [CAP_W-1:0]       room;
    logic [31:0]            total;
    logic [STORE_DEPTH-1:0] in_sack;
    int                     j;
    int                     k;
    int                     emit;
    if (set_count < STORE_DEPTH) begin
      set_store[set_count] = rec;
      set_count++;
    end else begin
      set_overflow = 1'b1;
    end
    if (closes_set) begin
      // stable insertion sort, ascending density
      for (j = 1; j < set_count; j++) begin
        key = set_store[j];
        k = j;
        while (k > 0 && denser(set_store[k-1], key)) begin
          set_store[k] = set_store[k-1];
          k--;
        end
        set_store[k] = key;
      end
      // fill from the densest item down, stop at the first misfit
      room = sack_size;
      total = '0;
      in_sack = '0;
      k = set_count;
      while (k > 0 && set_store[k-1].weight <= room) begin
        room = room - set_store[k-1].weight;
        in_sack[k-1] = 1'b1;
        total = total + set_store[k-1].price;
        if (total > TOTAL_MAX)
          total = TOTAL_MAX;
        k--;
      end
      emit = (set_count < RESULT_CAP) ? set_count : RESULT_CAP;
      for (k = 0; k < emit; k++) begin
        res.rank       = RANK_W'(k);
        res.tag        = set_store[k].tag;
        res.weight     = set_store[k].weight;
        res.price      = set_store[k].price;
        res.taken      = in_sack[k];
        res.kept_price = in_sack[k] ? set_store[k].price : '0;
        res.room_left  = room;
        res.total      = TOTAL_W'(total);
        res.dropped    = set_overflow;
        res.last_one   = (k + 1 == emit);
        ranks_due.push_back(res);
      end
      set_count = 0;
      set_overflow = 1'b0;
    end
  endtask

  // Gap length: mostly none or short, a few long
  function automatic int idle_span(input bit steady);
    int r;
    if (steady)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: present queued items, predict on each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      item_ch.valid <= 1'b0;
      load_gap = 0;
    end else begin
      if (item_ch.valid && item_ch.ready)
        predict_ranking('{weight: item_ch.item_weight, price: item_ch.item_price,
                          tag: item_ch.item_tag}, item_ch.last_item);
      if (!item_ch.valid || item_ch.ready) begin
        if (load_gap > 0) begin
          load_gap--;
          item_ch.valid <= 1'b0;
        end else if (pending_loads.size() != 0) begin
          next_load = pending_loads.pop_front();
          item_ch.item_weight <= next_load.rec.weight;
          item_ch.item_price  <= next_load.rec.price;
          item_ch.item_tag    <= next_load.rec.tag;
          item_ch.last_item   <= next_load.last;
          item_ch.valid       <= 1'b1;
          load_gap = idle_span(send_steady);
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result, stall the result channel at random
  always @(posedge clk) begin
    if (!rst_n) begin
      result_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (ranks_due.size() == 0) begin
          report_error($sformatf("result with nothing expected, rank %0d tag 0x%0h",
                                 result_ch.sorted_rank, result_ch.out_tag));
        end else begin
          want = ranks_due.pop_front();
          compare_field("sorted_rank", int'(want.rank), 32'(result_ch.sorted_rank),
                        32'(want.rank));
          compare_field("out_tag", int'(want.rank), 32'(result_ch.out_tag), 32'(want.tag));
          compare_field("out_weight", int'(want.rank), 32'(result_ch.out_weight),
                        32'(want.weight));
          compare_field("out_price", int'(want.rank), 32'(result_ch.out_price),
                        32'(want.price));
          compare_field("taken", int'(want.rank), 32'(result_ch.taken), 32'(want.taken));
          compare_field("taken_price", int'(want.rank), 32'(result_ch.taken_price),
                        32'(want.kept_price));
          compare_field("capacity_left", int'(want.rank), 32'(result_ch.capacity_left),
                        32'(want.room_left));
          compare_field("total_value", int'(want.rank), 32'(result_ch.total_value),
                        32'(want.total));
          compare_field("dropped", int'(want.rank), 32'(result_ch.dropped),
                        32'(want.dropped));
          compare_field("last_result", int'(want.rank), 32'(result_ch.last_result),
                        32'(want.last_one));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
        hold_left = idle_span(take_steady);
      end
    end
  end

  task automatic queue_item(input item_rec_t rec, input logic last);
    load_req_t req;
    req.rec = rec;
    req.last = last;
    pending_loads.push_back(req);
    items_queued++;
  endtask

  // Write the sack capacity; only called while the block is idle
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sack_size = value;
  endtask

  // Wait until every item is taken and every expected result has arrived
  task automatic settle();
    while (pending_loads.size() != 0 || item_ch.valid || ranks_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Build one well-formed set with random content and a fitting capacity
  task automatic random_set(input bit overflow_set);
    item_rec_t draft [$];
    item_rec_t rec;
    item_rec_t prev;
    logic [31:0] wsum;
    int n;
    int i;
    int r;
    int wclass;
    int wpick;
    int cap_hi;
    r = $urandom_range(0, 99);
    if (overflow_set || r < 10)
      n = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 6);
    else if (r < 25)
      n = $urandom_range(13, STORE_DEPTH);
    else
      n = $urandom_range(1, 12);
    wclass = $urandom_range(0, 3);
    wsum = '0;
    prev = '{weight: 16'd1, price: '0, tag: '0};
    for (i = 0; i < n; i++) begin
      wpick = (wclass == 3) ? $urandom_range(0, 2) : wclass;
      case (wpick)
        0: rec.weight = WEIGHT_W'($urandom_range(1, 16));
        1: rec.weight = WEIGHT_W'($urandom_range(1, 4095));
        default: rec.weight = WEIGHT_W'($urandom_range(1, 65535));
      endcase
      // mix equal densities, repeats and price extremes into the set
      r = $urandom_range(0, 99);
      if (r < 15) begin
        rec.price = PRICE_W'(rec.weight * $urandom_range(1, 3));
      end else if (r < 25 && i > 0) begin
        rec.weight = prev.weight;
        rec.price  = prev.price;
      end else if (r < 30) begin
        rec.price = '0;
      end else if (r < 35) begin
        rec.price = '1;
      end else if (r < 55) begin
        rec.price = PRICE_W'($urandom_range(0, 255));
      end else begin
        rec.price = PRICE_W'($urandom_range(0, 24'hFFFFFF));
      end
      rec.tag = TAG_W'($urandom_range(0, 65535));
      if (i < STORE_DEPTH)
        wsum = wsum + rec.weight;
      draft.push_back(rec);
      prev = rec;
    end
    r = $urandom_range(0, 99);
    cap_hi = wsum + wsum / 4 + 1;
    if (cap_hi > 65535)
      cap_hi = 65535;
    if (r < 8)
      write_capacity('0);
    else if (r < 16)
      write_capacity('1);
    else if (r < 85)
      write_capacity(CAP_W'($urandom_range(0, cap_hi)));
    send_steady = ($urandom_range(0, 5) == 0);
    take_steady = ($urandom_range(0, 5) == 0);
    for (i = 0; i < n; i++)
      queue_item(draft[i], i == n - 1);
  endtask

  // Stimulus and final verdict
  initial begin
    int target;
    bit first_set;
    item_ch.valid       = 1'b0;
    item_ch.item_weight = '0;
    item_ch.item_price  = '0;
    item_ch.item_tag    = '0;
    item_ch.last_item   = 1'b0;
    result_ch.ready     = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    rst_n               = 1'b0;
    set_count           = 0;
    set_overflow        = 1'b0;
    sack_size           = '0;
    mismatches          = 0;
    items_queued        = 0;
    send_steady         = 1'b0;
    take_steady         = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty sack: a single light item does not fit
    write_capacity('0);
    queue_item('{weight: 16'd1, price: '0, tag: '0}, 1'b1);
    settle();

    // full sack: densest fits, the heavy next one stops the fill; equal densities keep order
    write_capacity('1);
    queue_item('{weight: 16'hFFFF, price: 24'hFFFFFF, tag: 16'hFFFF}, 1'b0);
    queue_item('{weight: 16'd1, price: 24'hFFFFFF, tag: 16'd1}, 1'b0);
    queue_item('{weight: 16'd2, price: 24'd4, tag: 16'd2}, 1'b0);
    queue_item('{weight: 16'd1, price: 24'd2, tag: 16'd3}, 1'b0);
    queue_item('{weight: 16'd3, price: 24'd6, tag: 16'd4}, 1'b0);
    queue_item('{weight: 16'd4, price: '0, tag: 16'd5}, 1'b0);
    queue_item('{weight: 16'd10, price: 24'd5, tag: 16'd6}, 1'b1);
    settle();

    // exact fit: every item goes in the sack
    write_capacity(16'd20);
    queue_item('{weight: 16'd5, price: 24'd10, tag: 16'd7}, 1'b0);
    queue_item('{weight: 16'd5, price: 24'd10, tag: 16'd8}, 1'b0);
    queue_item('{weight: 16'd10, price: 24'd1, tag: 16'd9}, 1'b1);
    settle();

    // densest item does not fit: nothing is taken
    write_capacity(16'd3);
    queue_item('{weight: 16'd5, price: 24'd100, tag: 16'hAAAA}, 1'b0);
    queue_item('{weight: 16'd1, price: 24'd1, tag: 16'h5555}, 1'b1);
    settle();

    // random sets, the first one overfilling the store
    target = items_queued + RANDOM_ITEMS;
    first_set = 1'b1;
    while (items_queued < target) begin
      random_set(first_set);
      first_set = 1'b0;
      settle();
    end

    repeat (100) @(posedge clk);
    if (ranks_due.size() != 0)
      report_error($sformatf("%0d expected results never arrived", ranks_due.size()));
    if (mismatches == 0) begin
      $display("** greedy_knapsack_by_density: PASSED **");
    end else begin
      $display("** greedy_knapsack_by_density: FAILED **");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(LIMIT_NS);
    $display("** greedy_knapsack_by_density: FAILED **");
    $finish;
  end

endmodule
